// File: hdl/cpsnf_pkg.sv
package cpsnf_pkg;

  localparam int TowerDepth = 8192;
  localparam int TowerAw    = $clog2(TowerDepth);
  localparam int CountW     = TowerAw + 1;
  localparam int PhiSlots   = 128;
  localparam int PhiW       = 7;
  localparam int EtaSlots   = 128;
  localparam int EtaW       = 7;
  localparam int PhiStrips  = 72;
  localparam int EtaOffset  = 50;
  localparam int BadW       = 16;
  localparam int EnergyW    = 20;
  localparam int DivSteps   = 29;

  localparam logic [BadW-1:0]    BadMax    = '1;
  localparam logic [EnergyW-1:0] EnergyMax = '1;

  typedef struct packed {
    logic              fwd;
    logic [4:0]        prob;
    logic [15:0]       em;
    logic [15:0]       had;
    logic [PhiW-1:0]   phi;
    logic signed [6:0] eta;
  } tower_t;

  // slot = eta + 50, or eta + 49 for positive eta; returns 9 bits signed
  function automatic logic signed [8:0] eta_slot(input logic signed [6:0] eta);
    logic signed [8:0] e;
    e = 9'(eta);
    if (eta > 7'sd0) e = e - 9'sd1;
    return e + 9'(EtaOffset);
  endfunction

endpackage

// File: hdl/calo_phi_strip_noise_finder_core.sv
// Calorimeter phi-strip noise finder.
// Input stream s_axis_*: one tower per transfer, tlast closes the event.
//   tdata: eta_index[6:0], phi_index[13:7], had_energy[29:14],
//   em_energy[45:30], problem_cells[50:46], forward_tower[51], zero fill.
// Output stream m_axis_*: one result per event, held until taken.
// cfg_we/cfg_data write energy_eta_limit (reset 20); the user must do so only while idle (not enforced).
// Towers load at one per cycle into the tower memory (single port, read
// data registered). On the last tower the sequencer runs, in order:
//   strip clear, bad-count pass, worst scan, eta profile pass, run scan
//   (also clears the strip memory for the energies), energy pass, hottest
//   scan, neighbour reads, serial ratio divide, result register.
// Each pass reads the stored towers from the tower memory once per cycle;
// the bad-count and energy passes update the 128-entry strip memory with
// read-modify-write, forwarding the last written entry on back-to-back hits.
// Input is not accepted while the passes run or while a result waits.
// Reset clears control state; the strip memories are cleared per event.
// A stalled receiver holds the result and blocks the next event.
module calo_phi_strip_noise_finder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // eta_index, phi_index, had_energy, em_energy, problem_cells, forward_tower
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // worst_bad_strip, longest_run, hottest_strip, hottest_energy,
  // neighbour_sum, energy_ratio, ratio_undefined
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_data
);

  typedef enum logic [11:0] {
    ST_LOAD  = 12'b000000000001,
    ST_CLEAR = 12'b000000000010,
    ST_BAD   = 12'b000000000100,
    ST_WORST = 12'b000000001000,
    ST_PROF  = 12'b000000010000,
    ST_RUN   = 12'b000000100000,
    ST_ENER  = 12'b000001000000,
    ST_HOT   = 12'b000010000000,
    ST_NBR   = 12'b000100000000,
    ST_DIV   = 12'b001000000000,
    ST_OUT   = 12'b010000000000,
    ST_WAIT  = 12'b100000000000
  } state_t;

  state_t state;
  logic [5:0] eta_limit;

  cpsnf_pkg::tower_t tower_mem [cpsnf_pkg::TowerDepth];
  cpsnf_pkg::tower_t tower_rd;
  cpsnf_pkg::tower_t tower_q;
  logic [cpsnf_pkg::CountW-1:0] tower_count;
  logic [cpsnf_pkg::CountW-1:0] rd_idx;
  logic rd_v, proc_v;

  // strip memory: bad counts, strip energies; eta profile flags
  logic [cpsnf_pkg::EnergyW-1:0] strip_mem [cpsnf_pkg::PhiSlots];
  logic [cpsnf_pkg::EnergyW-1:0] strip_rd;
  logic prof_mem [cpsnf_pkg::EtaSlots];
  logic prof_rd;

  logic [7:0] sidx;
  logic [7:0] sidx_d;
  logic       scan_v;

  logic [cpsnf_pkg::PhiW-1:0] worst;
  logic [cpsnf_pkg::BadW-1:0] best_bad;
  logic [7:0] cur_run, best_run, run_end;
  logic [cpsnf_pkg::PhiW-1:0] hot;
  logic [cpsnf_pkg::EnergyW-1:0] hot_e;
  logic [cpsnf_pkg::EnergyW:0] nsum;
  logic [1:0] nstep;
  logic [cpsnf_pkg::PhiW-1:0] hot_sel;
  logic [cpsnf_pkg::EnergyW-1:0] nbr_hi;

  logic [28:0] div_rem;
  logic [28:0] div_num;
  logic [15:0] quo;
  logic [4:0]  dstep;

  // RMW forwarding on the strip memory
  logic                          wr_v;
  logic [cpsnf_pkg::PhiW-1:0]    wr_a;
  logic [cpsnf_pkg::EnergyW-1:0] wr_d;
  logic [cpsnf_pkg::PhiW-1:0]    rmw_a;
  logic [cpsnf_pkg::EnergyW-1:0] rmw_old;
  logic [cpsnf_pkg::EnergyW:0]   rmw_sum;
  logic                          rmw_en;
  logic [cpsnf_pkg::EnergyW-1:0] rmw_add;

  logic signed [8:0] slot_s;
  logic [6:0] abs_eta;

  cpsnf_pkg::tower_t in_tower;
  logic acc_in;
  logic [79:0] out_data;

  assign in_tower.eta  = s_axis_tdata[6:0];
  assign in_tower.phi  = s_axis_tdata[13:7];
  assign in_tower.had  = s_axis_tdata[29:14];
  assign in_tower.em   = s_axis_tdata[45:30];
  assign in_tower.prob = s_axis_tdata[50:46];
  assign in_tower.fwd  = s_axis_tdata[51];

  assign s_axis_tready = (state == ST_LOAD);
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == ST_WAIT);
  assign m_axis_tdata  = out_data;

  assign slot_s  = cpsnf_pkg::eta_slot(tower_q.eta);
  assign abs_eta = tower_q.eta[6] ? 7'(-tower_q.eta) : 7'(tower_q.eta);

  // hottest slot including the final scan element
  assign hot_sel = (scan_v && strip_rd > hot_e) ? sidx_d[cpsnf_pkg::PhiW-1:0] : hot;
  // upper neighbour past the last slot counts as zero
  assign nbr_hi = sidx[7] ? '0 : strip_rd;

  // pass-dependent decision on the tower whose strip entry was just read
  always_comb begin
    rmw_en  = 1'b0;
    rmw_add = '0;
    rmw_a   = tower_q.phi;
    if (proc_v && state == ST_BAD) begin
      rmw_en  = !tower_q.fwd;
      rmw_add = cpsnf_pkg::EnergyW'(tower_q.prob);
    end else if (proc_v && state == ST_ENER) begin
      rmw_en = (abs_eta <= 7'(eta_limit)) && (slot_s >= 9'sd0) &&
               (slot_s <= $signed({1'b0, run_end})) &&
               ($signed({1'b0, 8'(slot_s[7:0] + best_run)}) > $signed({1'b0, run_end}) ||
                (9'(slot_s) + 9'(best_run)) > 9'(run_end)) &&
               (best_run != 8'd0);
      rmw_add = cpsnf_pkg::EnergyW'((17'(tower_q.had) + 17'(tower_q.em)) >> 4);
    end
  end

  always_comb begin
    rmw_old = (wr_v && wr_a == rmw_a) ? wr_d : strip_rd;
    rmw_sum = (cpsnf_pkg::EnergyW + 1)'(rmw_old) + (cpsnf_pkg::EnergyW + 1)'(rmw_add);
  end

  // tower memory
  always_ff @(posedge clk) begin
    if (acc_in && tower_count < cpsnf_pkg::CountW'(cpsnf_pkg::TowerDepth))
      tower_mem[tower_count[cpsnf_pkg::TowerAw-1:0]] <= in_tower;
    tower_rd <= tower_mem[rd_idx[cpsnf_pkg::TowerAw-1:0]];
    tower_q  <= tower_rd;
  end

  // strip memory read address: the tower just read in the bad-count and energy passes, else the scan index
  logic [cpsnf_pkg::PhiW-1:0] strip_ra;
  always_comb begin
    strip_ra = sidx[cpsnf_pkg::PhiW-1:0];
    if (state == ST_BAD || state == ST_ENER) strip_ra = tower_rd.phi;
  end

  logic                          sw_en;
  logic [cpsnf_pkg::PhiW-1:0]    sw_a;
  logic [cpsnf_pkg::EnergyW-1:0] sw_d;
  logic                          pw_en;
  logic [cpsnf_pkg::EtaW-1:0]    pw_a;
  logic                          pw_d;

  always_comb begin
    sw_en = 1'b0;
    sw_a  = rmw_a;
    sw_d  = '0;
    pw_en = 1'b0;
    pw_a  = slot_s[6:0];
    pw_d  = tower_q.prob != 5'd0;
    if (state == ST_CLEAR) begin
      sw_en = 1'b1;
      sw_a  = sidx[cpsnf_pkg::PhiW-1:0];
      pw_en = 1'b1;
      pw_a  = sidx[cpsnf_pkg::EtaW-1:0];
      pw_d  = 1'b0;
    end else if (state == ST_RUN) begin
      // drop the bad counts before the energy pass
      sw_en = 1'b1;
      sw_a  = sidx[cpsnf_pkg::PhiW-1:0];
    end else if (rmw_en) begin
      sw_en = 1'b1;
      if (state == ST_BAD)
        sw_d = rmw_sum > 21'(cpsnf_pkg::BadMax) ?
               cpsnf_pkg::EnergyW'(cpsnf_pkg::BadMax) : rmw_sum[cpsnf_pkg::EnergyW-1:0];
      else
        sw_d = rmw_sum[cpsnf_pkg::EnergyW] ? cpsnf_pkg::EnergyMax :
               rmw_sum[cpsnf_pkg::EnergyW-1:0];
    end else if (proc_v && state == ST_PROF) begin
      pw_en = !tower_q.fwd && tower_q.phi == worst && slot_s >= 9'sd0 &&
              slot_s < 9'(cpsnf_pkg::EtaSlots);
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) strip_mem[sw_a] <= sw_d;
    strip_rd <= strip_mem[strip_ra];
    if (pw_en) prof_mem[pw_a] <= pw_d;
    prof_rd <= prof_mem[sidx[cpsnf_pkg::EtaW-1:0]];
    wr_v <= sw_en;
    wr_a <= sw_a;
    wr_d <= sw_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      eta_limit   <= 6'd20;
      tower_count <= '0;
      rd_idx      <= '0;
      rd_v        <= 1'b0;
      proc_v      <= 1'b0;
      sidx        <= '0;
      scan_v      <= 1'b0;
    end else begin
      if (cfg_we) eta_limit <= cfg_data;
      proc_v <= rd_v;
      case (state)
        ST_LOAD: begin
          if (acc_in) begin
            if (tower_count < cpsnf_pkg::CountW'(cpsnf_pkg::TowerDepth))
              tower_count <= tower_count + 1'b1;
            if (s_axis_tlast) begin
              state <= ST_CLEAR;
              sidx  <= '0;
            end
          end
        end
        ST_CLEAR: begin
          sidx <= sidx + 1'b1;
          if (sidx == 8'(cpsnf_pkg::PhiSlots - 1)) begin
            state  <= ST_BAD;
            rd_idx <= '0;
            rd_v   <= 1'b0;
          end
        end
        ST_BAD, ST_PROF, ST_ENER: begin
          // issue reads over the store, then drain the read pipeline (rd_v, proc_v)
          if (rd_idx < tower_count) begin
            rd_idx <= rd_idx + 1'b1;
            rd_v   <= 1'b1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v && !proc_v) begin
              sidx   <= '0;
              scan_v <= 1'b0;
              rd_idx <= '0;
              case (state)
                ST_BAD:  state <= ST_WORST;
                ST_PROF: state <= ST_RUN;
                default: state <= ST_HOT;
              endcase
            end
          end
        end
        ST_WORST: begin
          sidx   <= sidx + 1'b1;
          scan_v <= 1'b1;
          sidx_d <= sidx;
          if (scan_v && (sidx_d == 8'd0 || strip_rd[cpsnf_pkg::BadW-1:0] > best_bad)) begin
            best_bad <= strip_rd[cpsnf_pkg::BadW-1:0];
            worst    <= sidx_d[cpsnf_pkg::PhiW-1:0];
          end
          if (scan_v && sidx_d == 8'(cpsnf_pkg::PhiSlots - 1)) begin
            state <= ST_PROF;
            rd_v  <= 1'b0;
          end
        end
        ST_RUN: begin
          sidx   <= sidx + 1'b1;
          scan_v <= 1'b1;
          sidx_d <= sidx;
          if (scan_v) begin
            if (prof_rd) begin
              cur_run <= cur_run + 1'b1;
              if (cur_run + 1'b1 > best_run) begin
                best_run <= cur_run + 1'b1;
                run_end  <= sidx_d;
              end
            end else begin
              cur_run <= '0;
            end
            if (sidx_d == 8'(cpsnf_pkg::EtaSlots - 1)) begin
              state <= ST_ENER;
              rd_v  <= 1'b0;
            end
          end else begin
            cur_run  <= '0;
            best_run <= '0;
            run_end  <= '0;
          end
        end
        ST_HOT: begin
          sidx   <= sidx + 1'b1;
          scan_v <= 1'b1;
          sidx_d <= sidx;
          if (scan_v && sidx_d != 8'd0 &&
              (sidx_d == 8'd1 || strip_rd > hot_e)) begin
            hot_e <= strip_rd;
            hot   <= sidx_d[cpsnf_pkg::PhiW-1:0];
          end
          if (scan_v && sidx_d == 8'(cpsnf_pkg::PhiSlots - 1)) begin
            state <= ST_NBR;
            nstep <= '0;
            nsum  <= '0;
            sidx  <= (hot_sel == 7'd1) ? 8'(cpsnf_pkg::PhiStrips) : 8'(hot_sel) - 8'd1;
          end
        end
        ST_NBR: begin
          nstep <= nstep + 1'b1;
          if (nstep == 2'd0)
            sidx <= (hot == 7'(cpsnf_pkg::PhiStrips)) ? 8'd1 : 8'(hot) + 8'd1;
          if (nstep == 2'd1)
            nsum <= nsum + (cpsnf_pkg::EnergyW + 1)'(strip_rd);
          if (nstep == 2'd2) begin
            state   <= ST_DIV;
            dstep   <= '0;
            div_rem <= '0;
            quo     <= '0;
            nsum    <= nsum + (cpsnf_pkg::EnergyW + 1)'(nbr_hi);
            div_num <= {nsum + (cpsnf_pkg::EnergyW + 1)'(nbr_hi), 8'd0};
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle over the 29-bit dividend
          div_num <= {div_num[27:0], 1'b0};
          if ({div_rem[27:0], div_num[28]} >= 29'(hot_e)) begin
            div_rem <= {div_rem[27:0], div_num[28]} - 29'(hot_e);
            quo     <= quo[15] ? 16'hFFFF : {quo[14:0], 1'b1};
          end else begin
            div_rem <= {div_rem[27:0], div_num[28]};
            quo     <= quo[15] ? 16'hFFFF : {quo[14:0], 1'b0};
          end
          dstep <= dstep + 1'b1;
          if (dstep == 5'(cpsnf_pkg::DivSteps - 1)) state <= ST_OUT;
        end
        ST_OUT: begin
          out_data <= {1'b0,
                       (hot_e == '0),
                       (hot_e == '0) ? 16'hFFFF : quo,
                       nsum,
                       hot_e,
                       hot,
                       (best_run > 8'd127) ? 7'd127 : best_run[6:0],
                       worst};
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (m_axis_tready) begin
            state       <= ST_LOAD;
            tower_count <= '0;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  unused_guard: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted while a result waits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    tower_count <= cpsnf_pkg::CountW'(cpsnf_pkg::TowerDepth))
    else $error("tower count overflow");

  a_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> state == ST_CLEAR)
    else $error("last tower did not start passes");

endmodule

// File: dv/tb_calo_phi_strip_noise_finder_core.sv
module tb_calo_phi_strip_noise_finder_core;

  typedef struct packed {
    logic              last;
    logic              fwd;
    logic [4:0]        prob;
    logic [15:0]       em;
    logic [15:0]       had;
    logic [6:0]        phi;
    logic signed [6:0] eta;
  } tower_item_t;

  typedef struct packed {
    logic        undef;
    logic [15:0] ratio;
    logic [20:0] nsum;
    logic [19:0] hot_e;
    logic [6:0]  hot;
    logic [6:0]  run;
    logic [6:0]  worst;
  } strip_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_data = '0;

  calo_phi_strip_noise_finder_core u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  tower_item_t   pending_towers[$];
  strip_report_t expected_reports[$];
  tower_item_t   event_towers[$];
  logic [5:0]    eta_limit = 6'd20;
  int            errors = 0;
  int            towers_sent = 0;
  int            reports_seen = 0;
  int            events_sent = 0;
  bit            no_idle = 1'b0;
  longint        cycle = 0;

  function automatic int slot_of(int e);
    return (e > 0 ? e - 1 : e) + cpsnf_pkg::EtaOffset;
  endfunction

  function automatic strip_report_t predict_event();
    int unsigned bad[128];
    bit [4:0]    prof[128];
    int unsigned en[128];
    int unsigned best_bad, worst, cur, best_run, run_end, hot, hot_e, lo, hi, nsum;
    int          s, e, ae, n;
    longint unsigned r;
    strip_report_t rep;
    n = event_towers.size() > cpsnf_pkg::TowerDepth ? cpsnf_pkg::TowerDepth :
        event_towers.size();
    foreach (bad[i]) begin
      bad[i] = 0; prof[i] = 0; en[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      if (!event_towers[i].fwd) begin
        bad[event_towers[i].phi] += event_towers[i].prob;
        if (bad[event_towers[i].phi] > 65535) bad[event_towers[i].phi] = 65535;
      end
    end
    worst = 0; best_bad = bad[0];
    for (int i = 1; i < 128; i++) if (bad[i] > best_bad) begin
      best_bad = bad[i]; worst = i;
    end
    for (int i = 0; i < n; i++) begin
      if (event_towers[i].fwd || event_towers[i].phi != worst) continue;
      s = slot_of(event_towers[i].eta);
      if (s >= 0 && s < cpsnf_pkg::EtaSlots) prof[s] = event_towers[i].prob;
    end
    best_run = 0; run_end = 0; cur = 0;
    for (int i = 0; i < 128; i++) begin
      if (prof[i] != 0) begin
        cur++;
        if (cur > best_run) begin
          best_run = cur; run_end = i;
        end
      end else cur = 0;
    end
    if (best_run > 0) begin
      for (int i = 0; i < n; i++) begin
        e = event_towers[i].eta;
        ae = e < 0 ? -e : e;
        if (ae > eta_limit) continue;
        s = slot_of(e);
        if (s < 0 || s > run_end || s + best_run <= run_end) continue;
        en[event_towers[i].phi] += (event_towers[i].had + event_towers[i].em) >> 4;
        if (en[event_towers[i].phi] > 1048575) en[event_towers[i].phi] = 1048575;
      end
    end
    hot = 1; hot_e = en[1];
    for (int i = 2; i < 128; i++) if (en[i] > hot_e) begin
      hot_e = en[i]; hot = i;
    end
    lo = hot == 1 ? cpsnf_pkg::PhiStrips : hot - 1;
    hi = hot == cpsnf_pkg::PhiStrips ? 1 : hot + 1;
    nsum = en[lo] + (hi < 128 ? en[hi] : 0);
    if (hot_e == 0) begin
      rep.ratio = 16'hFFFF; rep.undef = 1'b1;
    end else begin
      r = (longint'(nsum) << 8) / hot_e;
      rep.ratio = r > 65535 ? 16'hFFFF : r[15:0];
      rep.undef = 1'b0;
    end
    rep.worst = worst[6:0];
    rep.run = best_run > 127 ? 7'd127 : best_run[6:0];
    rep.hot = hot[6:0];
    rep.hot_e = hot_e[19:0];
    rep.nsum = nsum[20:0];
    return rep;
  endfunction

  // driver: towers from the pending queue, random gaps
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        event_towers.insert(event_towers.size(), pending_towers.pop_front());
        towers_sent++;
        if (s_axis_tlast) begin
          expected_reports.insert(expected_reports.size(), predict_event());
          event_towers.delete();
          events_sent++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_towers.size() != 0 && (no_idle || $urandom_range(99) >= 18)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, pending_towers[0].fwd, pending_towers[0].prob,
                           pending_towers[0].em, pending_towers[0].had,
                           pending_towers[0].phi, pending_towers[0].eta};
          s_axis_tlast <= pending_towers[0].last;
        end else s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= no_idle || $urandom_range(99) >= 18;
    end
  end

  // monitor
  always @(posedge clk) begin
    strip_report_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[78:0];
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $error("unexpected report %h", got);
        errors++;
      end else begin
        want = expected_reports.pop_front();
        if (got.worst !== want.worst) begin
          $error("worst_bad_strip exp %0d got %0d", want.worst, got.worst); errors++;
        end
        if (got.run !== want.run) begin
          $error("longest_run exp %0d got %0d", want.run, got.run); errors++;
        end
        if (got.hot !== want.hot) begin
          $error("hottest_strip exp %0d got %0d", want.hot, got.hot); errors++;
        end
        if (got.hot_e !== want.hot_e) begin
          $error("hottest_energy exp %0d got %0d", want.hot_e, got.hot_e); errors++;
        end
        if (got.nsum !== want.nsum) begin
          $error("neighbour_sum exp %0d got %0d", want.nsum, got.nsum); errors++;
        end
        if (got.ratio !== want.ratio) begin
          $error("energy_ratio exp %0d got %0d", want.ratio, got.ratio); errors++;
        end
        if (got.undef !== want.undef) begin
          $error("ratio_undefined exp %0d got %0d", want.undef, got.undef); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > 3000000) begin
      $display("calo_phi_strip_noise_finder_core: mismatch");
      $finish;
    end
  end

  function automatic tower_item_t mk(int eta, int phi, int had, int em, int prob,
                                     bit fwd, bit last);
    tower_item_t t;
    t.eta = eta[6:0]; t.phi = phi[6:0]; t.had = had[15:0]; t.em = em[15:0];
    t.prob = prob[4:0]; t.fwd = fwd; t.last = last;
    return t;
  endfunction

  function automatic void queue_tower(tower_item_t t);
    pending_towers.insert(pending_towers.size(), t);
  endfunction

  function automatic int rand_eta();
    int e;
    case ($urandom_range(9))
      0: e = $urandom_range(127) - 64;
      1: e = $urandom_range(1) ? 41 : -41;
      default: e = $urandom_range(82) - 41;
    endcase
    return e;
  endfunction

  // a well-formed event: a band of flagged towers, mostly on one strip, plus scatter
  task automatic queue_event(int n);
    int strip, base, len;
    strip = $urandom_range(1, cpsnf_pkg::PhiStrips);
    base = $urandom_range(82) - 41;
    len = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6)
        queue_tower(mk(base + (i % len), $urandom_range(9) < 8 ? strip :
          (strip % cpsnf_pkg::PhiStrips) + 1, $urandom_range(65535), $urandom_range(4095),
          $urandom_range(1, 31), $urandom_range(19) == 0, i == n - 1));
      else
        queue_tower(mk(rand_eta(), $urandom_range(9) == 0 ?
          $urandom_range(127) : $urandom_range(1, cpsnf_pkg::PhiStrips),
          $urandom_range(65535), $urandom_range(65535),
          $urandom_range(3) ? 0 : $urandom_range(31),
          $urandom_range(9) == 0, i == n - 1));
    end
  endtask

  task automatic drain();
    while (pending_towers.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_limit(logic [5:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eta_limit = v;
  endtask

  initial begin
    int sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, forward-only event, wrap neighbours, eta zero
    queue_tower(mk(0, 0, 0, 0, 0, 0, 1));
    queue_tower(mk(-41, 1, 65535, 65535, 31, 0, 0));
    queue_tower(mk(-40, 1, 16, 16, 31, 0, 0));
    queue_tower(mk(-41, 72, 160, 0, 0, 0, 0));
    queue_tower(mk(-40, 2, 320, 0, 0, 0, 1));
    queue_tower(mk(5, 9, 1000, 1000, 31, 1, 1));
    queue_tower(mk(0, 72, 800, 0, 7, 0, 0));
    queue_tower(mk(1, 72, 800, 0, 9, 0, 0));
    queue_tower(mk(41, 72, 800, 0, 3, 0, 0));
    queue_tower(mk(0, 1, 1600, 0, 0, 0, 0));
    queue_tower(mk(1, 71, 1600, 0, 0, 0, 0));
    queue_tower(mk(-64, 127, 65535, 65535, 31, 0, 0));
    queue_tower(mk(63, 100, 65535, 0, 31, 0, 1));
    queue_tower(mk(10, 127, 65535, 65535, 31, 0, 0));
    queue_tower(mk(11, 127, 65535, 65535, 31, 0, 0));
    queue_tower(mk(12, 73, 5, 0, 2, 0, 1));
    drain();
    // random phases across several limits, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_limit(6'd0);
        1: set_limit(6'd41);
        2: set_limit(6'd63);
        3: set_limit(6'($urandom_range(41)));
        default: set_limit(6'd20);
      endcase
      no_idle = (ph == 2);
      sent = 0;
      while (sent < 300) begin
        int n;
        n = $urandom_range(20) == 0 ? $urandom_range(60, 120) : $urandom_range(1, 12);
        queue_event(n);
        sent += n;
      end
      drain();
    end
    no_idle = 1'b0;
    $display("covered %0d towers in %0d events, %0d reports checked",
             towers_sent, events_sent, reports_seen);
    if (errors == 0 && expected_reports.size() == 0)
      $display("calo_phi_strip_noise_finder_core: match");
    else
      $display("calo_phi_strip_noise_finder_core: mismatch");
    $finish;
  end
endmodule
